### hdl/fcc_pkg.sv
package fcc_pkg;

  localparam int unsigned COORD_W = 9;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam logic REG_RADIUS_SQ = 1'b0;

endpackage

### hdl/fcc_if.sv
interface fcc_restart_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface fcc_point_if
  import fcc_pkg::*;
;
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;
  logic   point_valid;
  logic   last_point;

  modport source (output valid, output point_x, output point_y, output point_z,
                  output point_valid, output last_point, input ready);
  modport sink (input valid, input point_x, input point_y, input point_z,
                input point_valid, input last_point, output ready);
endinterface

### hdl/fcc_sphere_point_enumerator.sv
// Lists the face-centred cubic lattice points (x+y+z even) inside a sphere of
// squared radius radius_sq, in x, then y, then z ascending order, one point per
// word taken on cmd; restart=1 (or the first word after reset) samples
// radius_sq and begins again from the first point. Once the list is used up,
// words carry point_valid=0. All column and row bounds come from one
// iterative integer square root unit that resolves one root bit per cycle,
// each root RB = (RADIUS_SQ_BITS+1)/2 bits wide (8 at the default), plus one
// shared squaring multiplier. A step inside a column goes through S_EMIT to a
// pending result that loads into the output register once that is free, and
// cmd is ready again as it loads. Leaving a column re-roots the current row
// and then roots the next column; running off the last row ends the list,
// and a restart roots the outer bound before its first row and column. cmd
// is not ready while a word is in work; a finished word waits in the output
// register while the next cmd word is taken.
module fcc_sphere_point_enumerator
  import fcc_pkg::*;
#(
  parameter int unsigned RADIUS_SQ_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  fcc_restart_if.sink cmd,
  fcc_point_if.source res
);

  localparam int unsigned RSQ   = RADIUS_SQ_BITS;
  localparam int unsigned RB    = (RSQ + 1) / 2;
  localparam int unsigned NB    = 2 * RB;
  localparam int unsigned CW    = RB + 2;
  localparam int unsigned CNT_W = $clog2(RB);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BEGIN,
    S_ROOT,
    S_XCHECK,
    S_XSUB,
    S_YCHECK,
    S_YSUB,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    ROOT_X,
    ROOT_Y,
    ROOT_Z
  } root_dst_t;

  state_t    state;
  root_dst_t root_dst;
  logic      seek_adv;
  logic      newrow;
  logic      done_pend;

  logic [RSQ-1:0] rsq;
  logic [RSQ-1:0] srsq;
  logic [RSQ-1:0] rx;
  logic           started;
  logic           finished;

  logic signed [CW-1:0] cur_x;
  logic signed [CW-1:0] cur_y;
  logic signed [CW-1:0] cur_z;
  logic [RB-1:0]        x_bound;
  logic [RB-1:0]        y_bound;
  logic [RB-1:0]        z_bound;
  logic [NB-1:0]        sq_reg;

  logic [NB-1:0]    rt_v;
  logic [RB:0]      rt_a;
  logic [RB-1:0]    rt_q;
  logic [CNT_W-1:0] rt_cnt;

  coord_t px;
  coord_t py;
  coord_t pz;
  logic   pvalid;
  logic   plast;

  logic [RB+2:0]        rt_s;
  logic [RB+2:0]        rt_t;
  logic                 rt_ge;
  logic [RB+2:0]        rt_diff;
  logic [RB:0]          rt_a_next;
  logic [RB-1:0]        rt_q_next;
  logic signed [CW-1:0] mul_src;
  logic [CW-1:0]        mul_abs_full;
  logic [RB-1:0]        mul_abs;
  logic [NB-1:0]        mul_prod;
  logic [NB-1:0]        sub_full;
  logic                 x_gt;
  logic                 y_gt;
  logic signed [CW:0]   z_plus;
  logic                 z_fit;
  logic                 z_odd;
  logic                 z_found;
  logic signed [CW-1:0] z_first;
  logic signed [CW+8:0] ext_x;
  logic signed [CW+8:0] ext_y;
  logic signed [CW+8:0] ext_z;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign prdata = 32'(rsq);
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_RADIUS_SQ);

  assign cmd.ready = (state == S_IDLE) && !done_pend;

  assign rt_s      = {rt_a, rt_v[NB-1 -: 2]};
  assign rt_t      = (RB+3)'({rt_q, 2'b01});
  assign rt_ge     = rt_s >= rt_t;
  assign rt_diff   = rt_s - rt_t;
  assign rt_a_next = rt_ge ? rt_diff[RB:0] : rt_s[RB:0];
  assign rt_q_next = {rt_q[RB-2:0], rt_ge};

  assign mul_src      = (state == S_XCHECK) ? cur_x : cur_y;
  assign mul_abs_full = mul_src[CW-1] ? CW'(-mul_src) : CW'(mul_src);
  assign mul_abs      = mul_abs_full[RB-1:0];
  assign mul_prod     = NB'(mul_abs) * NB'(mul_abs);
  assign sub_full     = (state == S_XSUB) ? (NB'(srsq) - sq_reg) : (NB'(rx) - sq_reg);

  assign x_gt   = cur_x > $signed(CW'(x_bound));
  assign y_gt   = cur_y > $signed(CW'(y_bound));
  assign z_plus = {cur_z[CW-1], cur_z} + $signed((CW+1)'(2));
  assign z_fit  = z_plus <= $signed((CW+1)'(z_bound));

  assign z_odd   = cur_x[0] ^ cur_y[0] ^ rt_q_next[0];
  assign z_found = !z_odd || (rt_q_next != '0);
  assign z_first = -$signed(CW'(rt_q_next)) + $signed(CW'(z_odd));

  assign ext_x = {{9{cur_x[CW-1]}}, cur_x};
  assign ext_y = {{9{cur_y[CW-1]}}, cur_y};
  assign ext_z = {{9{cur_z[CW-1]}}, cur_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      root_dst      <= ROOT_X;
      seek_adv      <= 1'b0;
      newrow        <= 1'b0;
      done_pend     <= 1'b0;
      rsq           <= RSQ'(2);
      srsq          <= '0;
      rx            <= '0;
      started       <= 1'b0;
      finished      <= 1'b0;
      cur_x         <= '0;
      cur_y         <= '0;
      cur_z         <= '0;
      x_bound       <= '0;
      y_bound       <= '0;
      z_bound       <= '0;
      res.valid     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        rsq <= pwdata[RSQ-1:0];
      end

      if (done_pend && (!res.valid || res.ready)) begin
        res.valid       <= 1'b1;
        res.point_x     <= px;
        res.point_y     <= py;
        res.point_z     <= pz;
        res.point_valid <= pvalid;
        res.last_point  <= plast;
        done_pend       <= 1'b0;
      end else if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd.valid && cmd.ready) begin
            if (cmd.restart || !started) begin
              srsq     <= rsq;
              started  <= 1'b1;
              finished <= 1'b0;
              state    <= S_BEGIN;
            end else begin
              state <= S_EMIT;
            end
          end
        end

        S_BEGIN: begin
          rt_v     <= NB'(srsq);
          rt_a     <= '0;
          rt_q     <= '0;
          rt_cnt   <= CNT_W'(RB - 1);
          root_dst <= ROOT_X;
          state    <= S_ROOT;
        end

        S_ROOT: begin
          rt_v   <= {rt_v[NB-3:0], 2'b00};
          rt_a   <= rt_a_next;
          rt_q   <= rt_q_next;
          rt_cnt <= rt_cnt - 1'b1;
          if (rt_cnt == '0) begin
            case (root_dst)
              ROOT_X: begin
                x_bound  <= rt_q_next;
                cur_x    <= -$signed(CW'(rt_q_next));
                cur_y    <= '0;
                newrow   <= 1'b1;
                seek_adv <= 1'b0;
                state    <= S_XCHECK;
              end
              ROOT_Y: begin
                y_bound <= rt_q_next;
                if (newrow) begin
                  cur_y <= -$signed(CW'(rt_q_next));
                end
                state <= S_YCHECK;
              end
              ROOT_Z: begin
                if (z_found) begin
                  z_bound <= rt_q_next;
                  cur_z   <= z_first;
                  if (seek_adv) begin
                    plast     <= 1'b0;
                    done_pend <= 1'b1;
                    state     <= S_IDLE;
                  end else begin
                    state <= S_EMIT;
                  end
                end else begin
                  cur_y <= cur_y + $signed(CW'(1));
                  state <= S_YCHECK;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        S_XCHECK: begin
          if (x_gt) begin
            finished <= 1'b1;
            if (seek_adv) begin
              plast     <= 1'b1;
              done_pend <= 1'b1;
              state     <= S_IDLE;
            end else begin
              state <= S_EMIT;
            end
          end else begin
            sq_reg <= mul_prod;
            state  <= S_XSUB;
          end
        end

        S_XSUB: begin
          rx       <= sub_full[RSQ-1:0];
          rt_v     <= NB'(sub_full[RSQ-1:0]);
          rt_a     <= '0;
          rt_q     <= '0;
          rt_cnt   <= CNT_W'(RB - 1);
          root_dst <= ROOT_Y;
          state    <= S_ROOT;
        end

        S_YCHECK: begin
          if (y_gt) begin
            cur_x  <= cur_x + $signed(CW'(1));
            newrow <= 1'b1;
            state  <= S_XCHECK;
          end else begin
            sq_reg <= mul_prod;
            state  <= S_YSUB;
          end
        end

        S_YSUB: begin
          rt_v          <= NB'(sub_full[RSQ-1:0]);
          rt_a          <= '0;
          rt_q          <= '0;
          rt_cnt        <= CNT_W'(RB - 1);
          root_dst      <= ROOT_Z;
          state         <= S_ROOT;
        end

        S_EMIT: begin
          if (finished) begin
            px        <= '0;
            py        <= '0;
            pz        <= '0;
            pvalid    <= 1'b0;
            plast     <= 1'b0;
            done_pend <= 1'b1;
            state     <= S_IDLE;
          end else begin
            px     <= ext_x[COORD_W-1:0];
            py     <= ext_y[COORD_W-1:0];
            pz     <= ext_z[COORD_W-1:0];
            pvalid <= 1'b1;
            if (z_fit) begin
              cur_z     <= z_plus[CW-1:0];
              plast     <= 1'b0;
              done_pend <= 1'b1;
              state     <= S_IDLE;
            end else begin
              cur_y    <= cur_y + $signed(CW'(1));
              newrow   <= 1'b0;
              seek_adv <= 1'b1;
              state    <= S_XCHECK;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> state != S_IDLE)
    else $error("accepted word did not start work");

  a_finished_started: assert property (@(posedge clk) disable iff (rst)
    finished |-> started)
    else $error("enumeration finished without a start");

  a_last_sets_finished: assert property (@(posedge clk) disable iff (rst)
    done_pend && pvalid && plast |-> finished)
    else $error("last point given while enumeration still open");

  a_empty_word_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.point_valid |-> !res.last_point && res.point_x == '0
      && res.point_y == '0 && res.point_z == '0)
    else $error("exhausted word carries nonzero fields");
`endif

endmodule
